@@ sv/ifrd_pkg.sv @@
`timescale 1ns / 1ps

package ifrd_pkg;

   localparam logic [7:0] FLAG_BYTE = 8'h7E;
   localparam logic [7:0] ESC_BYTE  = 8'h7D;
   localparam logic [7:0] ESC_FLAG  = 8'h5E;
   localparam logic [7:0] ESC_ESC   = 8'h5D;
   localparam logic [7:0] ADDR_BYTE = 8'h03;
   localparam logic [7:0] SET_CTRL  = 8'h03;
   localparam logic [7:0] UA_CTRL   = 8'h07;
   localparam logic [7:0] RR_BASE   = 8'hAA;
   localparam logic [7:0] REJ_BASE  = 8'h54;
   localparam logic [7:0] SEQ_BIT   = 8'h80;

   localparam logic [11:0] LIMIT_RESET = 12'd2000;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_FLAG,
      PH_ADDR,
      PH_SET_BCC,
      PH_SET_END,
      PH_INFO_BCC,
      PH_DATA
   } phase_type;

   typedef enum logic [2:0] {
      VERDICT_NEW      = 3'd0,
      VERDICT_DUP      = 3'd1,
      VERDICT_BCC2     = 3'd2,
      VERDICT_SET      = 3'd3,
      VERDICT_OVERFLOW = 3'd4
   } verdict_type;

   typedef struct packed {
      logic        out_kind;
      logic [7:0]  payload_byte;
      logic [2:0]  verdict;
      logic [7:0]  reply_control;
      logic [11:0] payload_length;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    item0;
      rsp_type    item1;
   } rsp_push_type;

endpackage

@@ sv/ifrd_rsp_fifo.sv @@
`timescale 1ns / 1ps

module ifrd_rsp_fifo
   import ifrd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  rsp_push_type push,
   output logic         room,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_item
);

   rsp_type                mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_PTR_W:0]     count_ff, count_in;
   logic [RSP_PTR_W-1:0]   wr_next_ptr;
   logic                   pop;

   assign rsp_valid   = (count_ff != '0);
   assign rsp_item    = mem_ff[rd_ptr_ff];
   assign pop         = rsp_valid && !rsp_stall;
   assign room        = (count_ff <= (RSP_PTR_W + 1)'(RSP_DEPTH - 2));
   assign wr_next_ptr = wr_ptr_ff + 1'b1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
      count_in  = count_ff + (RSP_PTR_W + 1)'(push.count) - (RSP_PTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next_ptr] <= push.item1;
      end
   end

endmodule

@@ sv/ifrd_core.sv @@
`timescale 1ns / 1ps

module ifrd_core
   import ifrd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_rx_byte,
   input  logic         csr_write_enable,
   input  logic [11:0]  csr_write_data,
   input  logic         room,
   output rsp_push_type push
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        fire, accept;

   phase_type   phase_ff, phase_in;
   logic        exp_ff, exp_in;
   logic        dup_ff, dup_in;
   logic        esc_ff, esc_in;
   logic [7:0]  held_ff, held_in;
   logic        held_valid_ff, held_valid_in;
   logic [7:0]  xor_ff, xor_in;
   logic [11:0] cnt_ff, cnt_in;
   logic [11:0] limit_ff, limit_in;

   logic [7:0]  b, seq_ctrl, info_ctrl, cand0, cand1, c;
   logic [1:0]  ncand, n;
   logic        ovf, finish, clear;
   rsp_type     r0, r1, item;

   function automatic rsp_type make_payload(logic [7:0] pb);
      rsp_type r;
      r              = '0;
      r.out_kind     = KIND_PAYLOAD;
      r.payload_byte = pb;
      return r;
   endfunction

   function automatic rsp_type make_verdict(logic [2:0] v, logic [7:0] rc, logic [11:0] len);
      rsp_type r;
      r                = '0;
      r.out_kind       = KIND_VERDICT;
      r.verdict        = v;
      r.reply_control  = rc;
      r.payload_length = len;
      return r;
   endfunction

   assign fire      = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign accept    = req_valid && !req_stall;
   assign b         = in_byte_ff;
   assign seq_ctrl  = {exp_ff, 7'b0};
   assign info_ctrl = {exp_ff ^ dup_ff, 7'b0};

   always_comb begin
      in_valid_in = accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
      limit_in    = csr_write_enable ? csr_write_data : limit_ff;
   end

   always_comb begin
      phase_in      = phase_ff;
      exp_in        = exp_ff;
      dup_in        = dup_ff;
      esc_in        = esc_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      xor_in        = xor_ff;
      cnt_in        = cnt_ff;
      cand0         = '0;
      cand1         = '0;
      c             = '0;
      ncand         = 2'd0;
      n             = 2'd0;
      ovf           = 1'b0;
      finish        = 1'b0;
      clear         = 1'b0;
      r0            = '0;
      r1            = '0;
      item          = '0;

      if (fire) begin
         unique case (phase_ff)
            PH_FLAG: begin
               if (b == FLAG_BYTE) phase_in = PH_FLAG;
               else if (b == ADDR_BYTE) phase_in = PH_ADDR;
               else phase_in = PH_HUNT;
            end
            PH_ADDR: begin
               if (b == FLAG_BYTE) begin
                  phase_in = PH_FLAG;
               end else if (b == seq_ctrl || b == (seq_ctrl ^ SEQ_BIT)) begin
                  clear    = 1'b1;
                  phase_in = PH_INFO_BCC;
               end else if (b == SET_CTRL) begin
                  phase_in = PH_SET_BCC;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_SET_BCC: begin
               if (b == FLAG_BYTE) phase_in = PH_FLAG;
               else if (b == (ADDR_BYTE ^ SET_CTRL)) phase_in = PH_SET_END;
               else phase_in = PH_HUNT;
            end
            PH_SET_END: begin
               if (b == FLAG_BYTE) begin
                  r0 = make_verdict(VERDICT_SET, UA_CTRL, 12'd0);
                  n  = 2'd1;
               end
               phase_in = PH_HUNT;
            end
            PH_INFO_BCC: begin
               if (b == FLAG_BYTE) begin
                  clear    = 1'b1;
                  phase_in = PH_FLAG;
               end else if (b == (ADDR_BYTE ^ info_ctrl)) begin
                  phase_in = PH_DATA;
               end else begin
                  clear    = 1'b1;
                  phase_in = PH_HUNT;
               end
            end
            PH_DATA: begin
               if (b == FLAG_BYTE) begin
                  finish = 1'b1;
                  if (esc_ff) begin
                     ncand = 2'd1;
                     cand0 = ESC_BYTE;
                  end
               end else begin
                  if (held_valid_ff) begin
                     esc_in = 1'b0;
                     if (esc_ff) begin
                        if (held_ff == ESC_FLAG) begin
                           ncand = 2'd1;
                           cand0 = FLAG_BYTE;
                        end else if (held_ff == ESC_ESC) begin
                           ncand = 2'd1;
                           cand0 = ESC_BYTE;
                        end else if (held_ff == ESC_BYTE) begin
                           ncand  = 2'd1;
                           cand0  = ESC_BYTE;
                           esc_in = 1'b1;
                        end else begin
                           ncand = 2'd2;
                           cand0 = ESC_BYTE;
                           cand1 = held_ff;
                        end
                     end else if (held_ff == ESC_BYTE) begin
                        esc_in = 1'b1;
                     end else begin
                        ncand = 2'd1;
                        cand0 = held_ff;
                     end
                  end
                  held_in       = b;
                  held_valid_in = 1'b1;
               end
            end
            default: begin
               phase_in = (b == FLAG_BYTE) ? PH_FLAG : PH_HUNT;
            end
         endcase
      end

      // destuffed bytes go out in order; the first one past the limit ends the frame
      for (int k = 0; k < 2; k++) begin
         if (2'(k) < ncand && !ovf) begin
            c = (k == 0) ? cand0 : cand1;
            if (cnt_in >= limit_ff) begin
               ovf  = 1'b1;
               item = make_verdict(VERDICT_OVERFLOW, 8'h00, cnt_in);
            end else begin
               item   = make_payload(c);
               xor_in = xor_in ^ c;
               cnt_in = cnt_in + 12'd1;
            end
            if (n == 2'd0) r0 = item;
            else r1 = item;
            n = n + 2'd1;
         end
      end

      if (ovf) begin
         clear    = 1'b1;
         phase_in = PH_HUNT;
      end else if (finish) begin
         if (!held_valid_ff || held_ff != xor_in) begin
            item = make_verdict(VERDICT_BCC2, REJ_BASE | {7'b0, exp_ff}, cnt_in);
         end else if (dup_ff) begin
            item = make_verdict(VERDICT_DUP, RR_BASE | {7'b0, exp_ff}, cnt_in);
         end else begin
            exp_in = ~exp_ff;
            item   = make_verdict(VERDICT_NEW, RR_BASE | {7'b0, ~exp_ff}, cnt_in);
         end
         if (n == 2'd0) r0 = item;
         else r1 = item;
         n        = n + 2'd1;
         clear    = 1'b1;
         phase_in = PH_HUNT;
      end

      if (clear) begin
         esc_in        = 1'b0;
         held_in       = '0;
         held_valid_in = 1'b0;
         xor_in        = '0;
         cnt_in        = '0;
         dup_in        = 1'b0;
      end
      // a new or duplicate frame opens here
      if (fire && phase_ff == PH_ADDR && phase_in == PH_INFO_BCC) begin
         dup_in = (b[7] != exp_ff);
      end

      if (n == 2'd1) r0.last = 1'b1;
      if (n == 2'd2) r1.last = 1'b1;

      push.count = n;
      push.item0 = r0;
      push.item1 = r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         phase_ff      <= PH_HUNT;
         exp_ff        <= 1'b0;
         dup_ff        <= 1'b0;
         esc_ff        <= 1'b0;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         xor_ff        <= '0;
         cnt_ff        <= '0;
         limit_ff      <= LIMIT_RESET;
      end else begin
         in_valid_ff   <= in_valid_in;
         phase_ff      <= phase_in;
         exp_ff        <= exp_in;
         dup_ff        <= dup_in;
         esc_ff        <= esc_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         xor_ff        <= xor_in;
         cnt_ff        <= cnt_in;
         limit_ff      <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   a_two_only_in_data: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> (fire && phase_ff == PH_DATA))
      else $error("two results outside the data phase");

   a_set_reply: assert property (@(posedge clock) disable iff (reset)
      (fire && phase_ff == PH_SET_END && in_byte_ff == FLAG_BYTE)
      |-> (push.count == 2'd1 && push.item0.reply_control == UA_CTRL && push.item0.last))
      else $error("SET frame did not produce a single UA verdict");

   a_seq_moves_on_verdict: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && exp_ff != $past(exp_ff))
      |-> ($past(fire) && $past(phase_ff) == PH_DATA && $past(push.count) != 2'd0))
      else $error("sequence changed without an end-of-frame verdict");

endmodule

@@ sv/info_frame_receiver_destuffer.sv @@
`timescale 1ns / 1ps

// Receiver for stop-and-wait information frames with byte destuffing.
// req_ channel: one raw line byte per beat (req_rx_byte), taken when
//   req_valid is high and req_stall is low.
// rsp_ channel: one result per beat; a provisional payload byte
//   (rsp_out_kind 0) or an end-of-frame verdict with reply control byte
//   and payload length (rsp_out_kind 1). rsp_last marks the final result
//   caused by one line byte; a byte yields zero, one or two results.
// csr_: csr_write_enable writes csr_write_data into the payload limit.
// A byte is held in an input register and its results are registered in
//   the result queue before rsp_valid shows them. Throughput: one byte per
//   cycle while the queue has room; bytes that yield two results are drained
//   one per cycle while rsp_stall is low through a four-entry result queue,
//   which stalls input when fewer than two slots are free.
// Reset: hunting for an opening flag, expected sequence 0, limit 2000,
//   result queue empty.
// When rsp_stall is high results wait in the queue; once fewer than two
//   slots are free, req_stall rises and holds the line side.
module info_frame_receiver_destuffer
   import ifrd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_out_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [2:0]  rsp_verdict,
   output logic [7:0]  rsp_reply_control,
   output logic [11:0] rsp_payload_length,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [11:0] csr_write_data
);

   rsp_push_type push;
   rsp_type      rsp_item;
   logic         room;

   ifrd_core u_core (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .room             (room),
      .push             (push)
   );

   ifrd_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   assign rsp_out_kind       = rsp_item.out_kind;
   assign rsp_payload_byte   = rsp_item.payload_byte;
   assign rsp_verdict        = rsp_item.verdict;
   assign rsp_reply_control  = rsp_item.reply_control;
   assign rsp_payload_length = rsp_item.payload_length;
   assign rsp_last           = rsp_item.last;

endmodule
